// ===== rtl/lifd_pkg.sv =====
// lifd_pkg: shared widths, register indexes and types for the fractional delay line
// used by lifd_mod and linear_interp_fractional_delay_unit; no dependencies
package lifd_pkg;

    localparam int MAX_LEN  = 4096;
    localparam int ADDR_W   = 12;
    localparam int LEN_W    = 13;
    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 16;
    localparam int DINT_W   = 12;
    localparam int DELAY_W  = DINT_W + FRAC_W;
    localparam int CNT_W    = 4;
    localparam int MIN_LEN  = 2;

    // configuration register indexes
    localparam logic REG_LINE_LENGTH = 1'b0;
    localparam logic REG_DELAY       = 1'b1;

    typedef enum logic {
        MOD_IDLE,
        MOD_RUN
    } mod_state_t;

    // read tap derived from the delay: integer offset back from the write index
    // (delay mod line length, rounded up to whole samples) and newer-sample weight
    typedef struct packed {
        logic [LEN_W-1:0]  offset;
        logic [FRAC_W-1:0] weight;
    } lifd_tap_t;

endpackage

// ===== rtl/lifd_mod.sv =====
// lifd_mod: reduces the integer part of the delay modulo the line length,
// one quotient bit per cycle, and forms the read tap; depends on lifd_pkg
module lifd_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lifd_pkg::LEN_W-1:0]    line_len,
    input  logic [lifd_pkg::DELAY_W-1:0]  delay,
    output logic                          busy,
    output lifd_pkg::lifd_tap_t           tap
);

    lifd_pkg::mod_state_t           state_reg, state_next;
    logic [lifd_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [lifd_pkg::ADDR_W-1:0]    rem_reg, rem_next;
    lifd_pkg::lifd_tap_t            tap_reg, tap_next;

    logic [lifd_pkg::DINT_W-1:0]    dint;
    logic [lifd_pkg::FRAC_W-1:0]    dfrac;
    logic [lifd_pkg::LEN_W-1:0]     trial;
    logic [lifd_pkg::LEN_W-1:0]     trial_sub;
    logic [lifd_pkg::ADDR_W-1:0]    rem_step;
    logic                           last_step;

    assign dint  = delay[lifd_pkg::DELAY_W-1:lifd_pkg::FRAC_W];
    assign dfrac = delay[lifd_pkg::FRAC_W-1:0];

    // restoring remainder step
    always_comb
    begin
        trial     = {rem_reg, dint[cnt_reg]};
        trial_sub = trial - line_len;
        rem_step  = (trial >= line_len) ? trial_sub[lifd_pkg::ADDR_W-1:0]
                                        : trial[lifd_pkg::ADDR_W-1:0];
        last_step = (cnt_reg == '0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lifd_pkg::MOD_IDLE:
            begin
                if (start)
                    state_next = lifd_pkg::MOD_RUN;
            end
            lifd_pkg::MOD_RUN:
            begin
                if (start)
                    state_next = lifd_pkg::MOD_RUN;
                else if (last_step)
                    state_next = lifd_pkg::MOD_IDLE;
            end
            default:
                state_next = lifd_pkg::MOD_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        tap_next = tap_reg;
        busy     = start;
        case (state_reg)
            lifd_pkg::MOD_IDLE:
            begin
                if (start)
                begin
                    cnt_next = lifd_pkg::CNT_W'(lifd_pkg::DINT_W - 1);
                    rem_next = '0;
                end
            end
            lifd_pkg::MOD_RUN:
            begin
                busy = 1'b1;
                if (start)
                begin
                    cnt_next = lifd_pkg::CNT_W'(lifd_pkg::DINT_W - 1);
                    rem_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    rem_next = rem_step;
                    if (last_step)
                    begin
                        // a fractional delay reaches one more sample back
                        tap_next.offset = {1'b0, rem_step}
                                        + lifd_pkg::LEN_W'(dfrac != '0);
                        tap_next.weight = (~dfrac) + 1'b1;
                    end
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lifd_pkg::MOD_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
    end

    assign tap = tap_reg;

endmodule

// ===== rtl/linear_interp_fractional_delay_unit.sv =====
// linear_interp_fractional_delay_unit: top level of the fractional delay line
// depends on lifd_pkg and lifd_mod
//
// usage:
//   s_* channel carries one input sample per item, m_* channel one delayed,
//   linearly interpolated sample per item, in the same order
//   cfg_wen/cfg_index/cfg_data write line_length (index 0) or delay_q16
//   (index 1); a line_length write saturates to 2..4096 and restarts the
//   write index at zero, the stored samples are kept
// timing:
//   after any configuration write, s_tready stays low while the delay is
//   reduced modulo the line length (one remainder bit per cycle)
//   an accepted item passes memory read, neighbor select, multiply and the
//   interpolate/output register; the single write and two read ports of the
//   store sustain one item per cycle while no stall or remainder holds it
// reset:
//   line length 4096, delay zero; the store reads as zeros through a fill
//   count (written entries always form a prefix), so there is no clearing pass
// backpressure:
//   when m_tready is low with an item waiting, the whole pipe holds and
//   s_tready drops; nothing is lost or duplicated
module linear_interp_fractional_delay_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lifd_pkg::SAMPLE_W-1:0]      s_tdata,   // [23:0] sample_in
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lifd_pkg::SAMPLE_W-1:0]      m_tdata,   // [23:0] sample_out
    // configuration writes
    input  logic                               cfg_wen,
    input  logic                               cfg_index,
    input  logic [lifd_pkg::DELAY_W-1:0]       cfg_data
);

    // configuration registers
    logic [lifd_pkg::LEN_W-1:0]    line_len_reg, line_len_next;
    logic [lifd_pkg::DELAY_W-1:0]  delay_reg, delay_next;
    logic [lifd_pkg::LEN_W-1:0]    len_sat;
    logic                          len_wr;

    // write side state
    logic [lifd_pkg::ADDR_W-1:0]   write_idx_reg, write_idx_next;
    logic [lifd_pkg::LEN_W-1:0]    fill_reg, fill_next;
    logic [lifd_pkg::LEN_W-1:0]    w_inc;

    // remainder unit
    logic                          mod_busy;
    lifd_pkg::lifd_tap_t           tap;

    // handshake
    logic                          pipe_en;
    logic                          in_fire;

    // read address generation
    logic [lifd_pkg::LEN_W:0]      pos_sum;
    logic [lifd_pkg::LEN_W:0]      pos_sub;
    logic [lifd_pkg::ADDR_W-1:0]   rd_i;
    logic [lifd_pkg::LEN_W-1:0]    rd_j_inc;
    logic [lifd_pkg::ADDR_W-1:0]   rd_j;

    // sample store
    logic [lifd_pkg::SAMPLE_W-1:0] store_mem [lifd_pkg::MAX_LEN];
    logic [lifd_pkg::SAMPLE_W-1:0] rd_a_reg, rd_b_reg;

    // stage 1: after the memory read
    logic                          v1_reg, v1_next;
    logic                          fwd_a_reg, fwd_b_reg;
    logic                          ok_a_reg, ok_b_reg;
    logic [lifd_pkg::SAMPLE_W-1:0] smp1_reg;
    logic [lifd_pkg::FRAC_W-1:0]   frac1_reg;

    // stage 2: neighbors picked, difference formed
    logic                          v2_reg, v2_next;
    logic signed [lifd_pkg::SAMPLE_W-1:0] a_sel, b_sel;
    logic signed [lifd_pkg::SAMPLE_W:0]   diff;
    logic signed [lifd_pkg::SAMPLE_W-1:0] a2_reg;
    logic signed [lifd_pkg::SAMPLE_W:0]   diff2_reg;
    logic [lifd_pkg::FRAC_W-1:0]          frac2_reg;

    // stage 3: weighted difference
    logic                          v3_reg, v3_next;
    logic signed [lifd_pkg::SAMPLE_W+lifd_pkg::FRAC_W+1:0] prod;
    logic signed [lifd_pkg::SAMPLE_W-1:0] a3_reg;
    logic [lifd_pkg::SAMPLE_W-1:0]        prod3_reg;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [lifd_pkg::SAMPLE_W-1:0] out_data_reg;
    logic [lifd_pkg::SAMPLE_W-1:0] interp;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_comb
    begin
        if (cfg_data[lifd_pkg::LEN_W-1:0] < lifd_pkg::LEN_W'(lifd_pkg::MIN_LEN))
            len_sat = lifd_pkg::LEN_W'(lifd_pkg::MIN_LEN);
        else if (cfg_data[lifd_pkg::LEN_W-1:0] > lifd_pkg::LEN_W'(lifd_pkg::MAX_LEN))
            len_sat = lifd_pkg::LEN_W'(lifd_pkg::MAX_LEN);
        else
            len_sat = cfg_data[lifd_pkg::LEN_W-1:0];

        len_wr        = cfg_wen && (cfg_index == lifd_pkg::REG_LINE_LENGTH);
        line_len_next = line_len_reg;
        delay_next    = delay_reg;
        if (len_wr)
            line_len_next = len_sat;
        if (cfg_wen && (cfg_index == lifd_pkg::REG_DELAY))
            delay_next = cfg_data;
    end

    // any write changes the delay modulo, so rerun the remainder
    lifd_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_wen),
        .line_len (line_len_reg),
        .delay    (delay_reg),
        .busy     (mod_busy),
        .tap      (tap)
    );

    // ------------------------------------------------------------------
    // handshake: the whole pipe moves unless the output item is stalled
    // ------------------------------------------------------------------
    assign pipe_en  = !out_valid_reg || m_tready;
    assign s_tready = pipe_en && !mod_busy;
    assign in_fire  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // read positions: i = (w - offset) mod len, j = (i + 1) mod len
    // ------------------------------------------------------------------
    always_comb
    begin
        pos_sum  = {2'b00, write_idx_reg} + {1'b0, line_len_reg} - {1'b0, tap.offset};
        pos_sub  = pos_sum - {1'b0, line_len_reg};
        rd_i     = (pos_sum >= {1'b0, line_len_reg}) ? pos_sub[lifd_pkg::ADDR_W-1:0]
                                                     : pos_sum[lifd_pkg::ADDR_W-1:0];
        rd_j_inc = {1'b0, rd_i} + 1'b1;
        rd_j     = (rd_j_inc == line_len_reg) ? '0 : rd_j_inc[lifd_pkg::ADDR_W-1:0];
    end

    // write index and fill count
    always_comb
    begin
        w_inc          = {1'b0, write_idx_reg} + 1'b1;
        write_idx_next = write_idx_reg;
        fill_next      = fill_reg;
        if (in_fire)
        begin
            write_idx_next = (w_inc == line_len_reg) ? '0 : w_inc[lifd_pkg::ADDR_W-1:0];
            if (w_inc > fill_reg)
                fill_next = w_inc;
        end
        if (len_wr)
            write_idx_next = '0;
    end

    // ------------------------------------------------------------------
    // sample store: one write, two reads, registered read data
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            store_mem[write_idx_reg] <= s_tdata;
            rd_a_reg                 <= store_mem[rd_i];
            rd_b_reg                 <= store_mem[rd_j];
        end
    end

    // ------------------------------------------------------------------
    // pipeline valids
    // ------------------------------------------------------------------
    always_comb
    begin
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        v3_next        = v3_reg;
        out_valid_next = out_valid_reg;
        if (pipe_en)
        begin
            v1_next        = in_fire;
            v2_next        = v1_reg;
            v3_next        = v2_reg;
            out_valid_next = v3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg  <= lifd_pkg::LEN_W'(lifd_pkg::MAX_LEN);
            delay_reg     <= '0;
            write_idx_reg <= '0;
            fill_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            line_len_reg  <= line_len_next;
            delay_reg     <= delay_next;
            write_idx_reg <= write_idx_next;
            fill_reg      <= fill_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: note forwarding of the sample written this cycle and
    // whether each entry has ever been written
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fwd_a_reg <= (rd_i == write_idx_reg);
            fwd_b_reg <= (rd_j == write_idx_reg);
            ok_a_reg  <= ({1'b0, rd_i} < fill_reg);
            ok_b_reg  <= ({1'b0, rd_j} < fill_reg);
            smp1_reg  <= s_tdata;
            frac1_reg <= tap.weight;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: pick neighbors, older a and newer b
    // ------------------------------------------------------------------
    always_comb
    begin
        if (fwd_a_reg)
            a_sel = smp1_reg;
        else if (ok_a_reg)
            a_sel = rd_a_reg;
        else
            a_sel = '0;

        if (fwd_b_reg)
            b_sel = smp1_reg;
        else if (ok_b_reg)
            b_sel = rd_b_reg;
        else
            b_sel = '0;

        diff = {b_sel[lifd_pkg::SAMPLE_W-1], b_sel} - {a_sel[lifd_pkg::SAMPLE_W-1], a_sel};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a2_reg    <= a_sel;
            diff2_reg <= diff;
            frac2_reg <= frac1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: (b - a) * f; a*(1-f) + b*f floored equals a + floor((b-a)*f)
    // ------------------------------------------------------------------
    assign prod = diff2_reg * $signed({1'b0, frac2_reg});

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a3_reg    <= a2_reg;
            prod3_reg <= prod[lifd_pkg::SAMPLE_W+lifd_pkg::FRAC_W-1:lifd_pkg::FRAC_W];
        end
    end

    // result lies between a and b, so the low bits are exact
    assign interp = a3_reg + prod3_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            out_data_reg <= interp;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_widx_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> ({1'b0, write_idx_reg} < line_len_reg))
        else $error("write index outside the active line");

    a_reads_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (({1'b0, rd_i} < line_len_reg) && ({1'b0, rd_j} < line_len_reg)))
        else $error("read position outside the active line");

    a_len_restart: assert property (@(posedge clk) disable iff (!rst_n)
        len_wr |=> (write_idx_reg == '0))
        else $error("line length write did not restart the write index");

    a_tap_offset: assert property (@(posedge clk) disable iff (!rst_n)
        !mod_busy |-> (tap.offset <= line_len_reg))
        else $error("read offset beyond the line length");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cfg_wen) |-> !in_fire)
        else $error("item taken while the delay remainder was stale");

endmodule

// ===== tb/lifd_checker.sv =====
// lifd_checker: watches the config port and both item channels of the fractional delay line,
// predicts every delayed sample and compares it with the block's output
// depends on lifd_pkg
module lifd_checker
    import lifd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,    // [23:0] sample_in
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [SAMPLE_W-1:0] m_tdata,    // [23:0] sample_out
    input  logic                cfg_wen,
    input  logic                cfg_index,
    input  logic [DELAY_W-1:0]  cfg_data,
    output int                  pending,
    output int                  fail_count
);

    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the circular store and the line settings
    logic signed [SAMPLE_W-1:0] line_mem [MAX_LEN];
    int unsigned                wr_ptr;
    int unsigned                active_len;
    logic [DELAY_W-1:0]         delay_fx;

    logic signed [SAMPLE_W-1:0] expected_samples [$];
    logic signed [SAMPLE_W-1:0] predicted;
    logic signed [SAMPLE_W-1:0] oldest;
    logic [LEN_W-1:0]           len_field;

    // store the new sample, then blend the two neighbors around the read position
    task automatic write_and_interpolate(input logic signed [SAMPLE_W-1:0] sample,
                                         output logic signed [SAMPLE_W-1:0] blended);
        longint unsigned span;
        longint unsigned dly;
        longint unsigned pos;
        int unsigned     rd_a;
        int unsigned     rd_b;
        longint          older;
        longint          newer;
        longint          weight;
        longint          acc;
        longint          shifted;
        span = longint'(active_len) << FRAC_W;
        dly  = longint'(delay_fx) % span;
        line_mem[wr_ptr] = sample;
        pos = (longint'(wr_ptr) << FRAC_W) + span - dly;
        if (pos >= span)
            pos = pos - span;
        rd_a   = int'(pos >> FRAC_W);
        weight = longint'(pos & ((64'd1 << FRAC_W) - 1));
        rd_b   = rd_a + 1;
        if (rd_b >= active_len)
            rd_b = 0;
        older   = line_mem[rd_a];
        newer   = line_mem[rd_b];
        acc     = older * ((64'sd1 <<< FRAC_W) - weight) + newer * weight;
        shifted = acc >>> FRAC_W;
        blended = shifted[SAMPLE_W-1:0];
        wr_ptr  = (wr_ptr + 1 >= active_len) ? 0 : wr_ptr + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_LEN; k++)
                line_mem[k] = '0;
            wr_ptr     = 0;
            active_len = MAX_LEN;
            delay_fx   = '0;
            expected_samples.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_LINE_LENGTH:
                    begin
                        len_field = cfg_data[LEN_W-1:0];
                        if (len_field < MIN_LEN)
                            active_len = MIN_LEN;
                        else if (len_field > MAX_LEN)
                            active_len = MAX_LEN;
                        else
                            active_len = len_field;
                        wr_ptr = 0;
                    end
                    REG_DELAY:
                        delay_fx = cfg_data;
                endcase
            end
            // results are checked before this edge's input is predicted
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("sample_out: no item expected, actual %0d", $signed(m_tdata));
                    fail_count++;
                end
                else
                begin
                    oldest = expected_samples.pop_front();
                    if (m_tdata !== oldest)
                    begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               oldest, $signed(m_tdata));
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                write_and_interpolate(s_tdata, predicted);
                expected_samples.push_back(predicted);
            end
            pending = expected_samples.size();
        end
    end

endmodule

// ===== tb/tb_linear_interp_fractional_delay_unit.sv =====
// tb_linear_interp_fractional_delay_unit: drives the fractional delay line with directed and
// random samples across many line settings, with random idling on both channels
// depends on lifd_pkg, linear_interp_fractional_delay_unit and lifd_checker
module tb_linear_interp_fractional_delay_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import lifd_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 200000;
    // a bit beyond the pipe before touching the registers or ending
    localparam int SETTLE       = 8;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;     // [23:0] sample_in
    logic                m_tvalid;
    logic                m_tready;
    logic [SAMPLE_W-1:0] m_tdata;     // [23:0] sample_out
    logic                cfg_wen;
    logic                cfg_index;
    logic [DELAY_W-1:0]  cfg_data;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int tx_calm;
    int cur_len;

    always #1 clk = ~clk;

    linear_interp_fractional_delay_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lifd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stall before each item, with stretches of no stall at all
    initial
    begin
        int stall;
        int calm;
        m_tready = 1'b0;
        calm = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (calm > 0)
            begin
                stall = 0;
                calm--;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                calm  = $urandom_range(10, 40);
                stall = 0;
            end
            else
                stall = $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            // m_tready was already high before each of these edges
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // input side: random gap before each item, valid stays up between back-to-back items
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        if (tx_calm > 0)
        begin
            gap = 0;
            tx_calm--;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            tx_calm = $urandom_range(10, 40);
            gap = 0;
        end
        else
            gap = $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop sending and wait until every predicted sample has come out
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // one register write; the extra edge keeps two writes from colliding in one step
    task automatic cfg_write(input logic idx, input logic [DELAY_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        @(posedge clk);
    endtask

    // new line setting while idle; tracks the length the block should settle on
    task automatic retune(input bit wr_len, input logic [DELAY_W-1:0] len_word,
                          input bit wr_dly, input logic [DELAY_W-1:0] delay_word);
        drain_pipe();
        if (wr_len)
        begin
            cfg_write(REG_LINE_LENGTH, len_word);
            // only the low 13 bits count, then the range clamps
            if (len_word[LEN_W-1:0] < MIN_LEN)
                cur_len = MIN_LEN;
            else if (len_word[LEN_W-1:0] > MAX_LEN)
                cur_len = MAX_LEN;
            else
                cur_len = len_word[LEN_W-1:0];
        end
        if (wr_dly)
            cfg_write(REG_DELAY, delay_word);
    endtask

    initial
    begin
        logic [DELAY_W-1:0]  len_word;
        logic [DELAY_W-1:0]  delay_word;
        logic [SAMPLE_W-1:0] sample;
        longint              multiple;
        int                  sent;
        int                  burst;
        int                  mode;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wen   = 1'b0;
        cfg_index = REG_LINE_LENGTH;
        cfg_data  = '0;
        tx_calm   = 0;
        cur_len   = MAX_LEN;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: zero delay, so each output is its own input
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h000000);
        send_sample(24'hFFFFFF);
        send_sample(24'h000001);
        send_sample(24'h555555);
        send_sample(24'hAAAAAA);

        // length below range clamps to 2, delay of one and a half samples
        retune(1'b1, 28'd0, 1'b1, 28'h0018000);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h800000);
        send_sample(24'h7FFFFF);

        // length above range clamps to 4096, largest delay reads just past the write
        retune(1'b1, 28'd8191, 1'b1, 28'hFFFFFFF);
        send_sample(24'h800000);
        send_sample(24'h7FFFFF);
        send_sample(24'h123456);

        // upper data bits ignored (length 3), delay equal to the line wraps to zero
        retune(1'b1, 28'h0002003, 1'b1, 28'h0030000);
        send_sample(24'h800001);
        send_sample(24'h7FFFFE);
        send_sample(24'h000000);

        // length one clamps to 2, half-sample delay
        retune(1'b1, 28'd1, 1'b1, 28'h0008000);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'hFFFFFF);

        // full line with the delay one step short of 256 samples
        retune(1'b1, 28'd5000, 1'b1, 28'h0FFFFFF);
        send_sample(24'h400000);
        send_sample(24'hC00000);
        send_sample(24'h7FFFFF);

        // random phases: new setting, then a burst of random samples
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0:       len_word = $urandom_range(0, 1);
                1:       len_word = MIN_LEN;
                2:       len_word = MAX_LEN;
                3:       len_word = $urandom_range(MAX_LEN + 1, 8191);
                4, 5:    len_word = $urandom_range(MIN_LEN, 64);
                6:       len_word = $urandom_range(MIN_LEN, MAX_LEN);
                default: len_word = $urandom();
            endcase
            // both registers or one alone; with delay alone the write index keeps going
            mode = $urandom_range(0, 3);
            if (mode != 2)
            begin
                retune(1'b1, len_word, 1'b0, '0);
            end
            case ($urandom_range(0, 7))
                0:       delay_word = '0;
                1:       delay_word = $urandom();
                2:
                begin
                    // whole multiples of the line length, cut to the delay's integer width
                    multiple   = longint'($urandom_range(1, 4)) * cur_len;
                    delay_word = multiple << FRAC_W;
                end
                3, 4, 5: delay_word = $urandom_range(0, cur_len * 65536 - 1);
                6:       delay_word = $urandom_range(0, cur_len - 1) << FRAC_W;
                default: delay_word = $urandom_range(0, 65535);
            endcase
            if (mode != 3)
                retune(1'b0, '0, 1'b1, delay_word);
            burst = $urandom_range(5, 40);
            for (int n = 0; n < burst; n++)
            begin
                sample = $urandom();
                if ($urandom_range(0, 9) == 0)
                    sample = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                send_sample(sample);
            end
            sent += burst;
        end

        drain_pipe();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
